>>> sv/tail_area_fdr_lookup_defines.svh
// assertion macros for the tail area fdr lookup
`ifndef TAIL_AREA_FDR_LOOKUP_DEFINES_SVH
`define TAIL_AREA_FDR_LOOKUP_DEFINES_SVH
`ifndef SYNTH
`define TAFL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TAFL_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TAFL_ASSERT(label, clk, rst, prop, msg)
`define TAFL_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

>>> sv/tafl_pkg.sv
package tafl_pkg;

   localparam int GRID_POINTS_DEF = 1024;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int INDEX_W = 10;
   localparam int SCORE_W = 24;
   localparam int DENS_W = 32;
   localparam int FDR_W = 32;
   localparam int TAIL_W = 48;
   localparam int WEIGHT_W = 17;
   localparam int WPROD_W = 56;
   localparam int PROD_W = 51;
   localparam int LOC_W = 49;
   localparam int FD_W = 34;
   localparam int GLOB_W = 64;
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_TICK_STEP = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_STEP_RECIP = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_SCORE_FLOOR = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_RATIO = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_DENS_FLOOR = 3'd4;

   localparam logic [23:0] RST_TICK_STEP = 24'd1;
   localparam logic [31:0] RST_STEP_RECIP = 32'hFFFF_FFFF;
   localparam logic [23:0] RST_SCORE_FLOOR = 24'd6554;
   localparam logic [31:0] RST_RATIO = 32'd16777216;
   localparam logic [31:0] RST_DENS_FLOOR = 32'd1;

   localparam logic [1:0] REQ_LOAD = 2'd0;
   localparam logic [1:0] REQ_FINISH = 2'd1;
   localparam logic [1:0] REQ_QUERY = 2'd2;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_SAT = 2'd1;
   localparam logic [1:0] STATUS_NOT_READY = 2'd2;

   typedef enum logic [1:0] {CMD_LOAD, CMD_FINISH, CMD_QUERY} cmd_kind_type;

   typedef struct packed {
      logic [1:0]         req_type;
      logic               curve;
      logic [INDEX_W-1:0] tick_index;
      logic [DENS_W-1:0]  density;
      logic [SCORE_W-1:0] score;
   } req_item_type;

   typedef struct packed {
      logic [FDR_W-1:0] local_fdr;
      logic [FDR_W-1:0] global_fdr;
      logic [1:0]       status;
   } rsp_item_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic               curve;
      logic [INDEX_W-1:0] index;
      logic [DENS_W-1:0]  value;
   } cmd_type;

   typedef struct packed {
      logic [23:0] tick_step;
      logic [31:0] step_recip;
      logic [23:0] score_floor;
      logic [31:0] ratio;
      logic [31:0] dens_floor;
   } csr_type;

   typedef struct packed {
      logic              start;
      logic [31:0]       ratio;
      logic [GLOB_W-1:0] num;
      logic [GLOB_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [FDR_W-1:0] quo;
      logic             sat;
   } div_rsp_type;

endpackage

>>> sv/tafl_front.sv
module tafl_front #(
   parameter int GRID_POINTS = tafl_pkg::GRID_POINTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  tafl_pkg::req_item_type req_item,
   input  tafl_pkg::csr_type     csr,
   output tafl_pkg::cmd_type     cmd,
   output logic                  cmd_empty,
   input  logic                  cmd_pop
);

   tafl_pkg::cmd_type q_ff [tafl_pkg::QUEUE_DEPTH];
   logic [tafl_pkg::QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [tafl_pkg::QCNT_W-1:0] cnt_ff;
   tafl_pkg::cmd_type cmd_in;
   logic keep, enq;

   // classify: floor densities and scores, drop unused codes and stray indexes
   always_comb begin
      cmd_in = '0;
      keep = 1'b0;
      cmd_in.curve = req_item.curve;
      cmd_in.index = req_item.tick_index;
      unique case (req_item.req_type)
         tafl_pkg::REQ_LOAD: begin
            cmd_in.kind = tafl_pkg::CMD_LOAD;
            cmd_in.value = (req_item.density < csr.dens_floor) ? csr.dens_floor
                                                                : req_item.density;
            keep = 32'(req_item.tick_index) < 32'(GRID_POINTS);
         end
         tafl_pkg::REQ_FINISH: begin
            cmd_in.kind = tafl_pkg::CMD_FINISH;
            keep = 1'b1;
         end
         tafl_pkg::REQ_QUERY: begin
            cmd_in.kind = tafl_pkg::CMD_QUERY;
            cmd_in.value = 32'((req_item.score < csr.score_floor) ? csr.score_floor
                                                                   : req_item.score);
            keep = 1'b1;
         end
         default: keep = 1'b0;
      endcase
   end

   assign full = (cnt_ff == tafl_pkg::QCNT_W'(tafl_pkg::QUEUE_DEPTH));
   assign enq = push && !full && keep;
   assign cmd_empty = (cnt_ff == '0);
   assign cmd = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (enq) begin
         q_ff[wr_ptr_ff] <= cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (enq) begin
            wr_ptr_ff <= (wr_ptr_ff == tafl_pkg::QPTR_W'(tafl_pkg::QUEUE_DEPTH - 1)) ? '0
                         : wr_ptr_ff + 1'b1;
         end
         if (cmd_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == tafl_pkg::QPTR_W'(tafl_pkg::QUEUE_DEPTH - 1)) ? '0
                         : rd_ptr_ff + 1'b1;
         end
         if (enq && !cmd_pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (!enq && cmd_pop) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

endmodule

>>> sv/tafl_div.sv
module tafl_div (
   input  logic                  clock,
   input  logic                  reset,
   input  tafl_pkg::div_req_type req,
   output tafl_pkg::div_rsp_type rsp
);

   typedef enum logic [2:0] {D_IDLE, D_MLO, D_MHI, D_SUM, D_CLS, D_ITER} dstate_type;

   dstate_type state_ff;
   logic [31:0] r_ff;
   logic [63:0] n_ff, d_ff, plo_ff, phi_ff, rem_ff;
   logic [95:0] p_ff;
   logic [31:0] low_ff, quo_ff;
   logic [4:0] cnt_ff;
   logic done_ff, sat_ff;
   logic [64:0] trial;
   logic ge;

   // one quotient bit per cycle
   assign trial = {rem_ff, low_ff[31]};
   assign ge = trial >= {1'b0, d_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            D_IDLE: begin
               if (req.start) begin
                  r_ff <= req.ratio;
                  n_ff <= req.num;
                  d_ff <= req.den;
                  state_ff <= D_MLO;
               end
            end
            D_MLO: begin
               plo_ff <= 64'(r_ff) * 64'(n_ff[31:0]);
               state_ff <= D_MHI;
            end
            D_MHI: begin
               phi_ff <= 64'(r_ff) * 64'(n_ff[63:32]);
               state_ff <= D_SUM;
            end
            D_SUM: begin
               p_ff <= {phi_ff, 32'b0} + {32'b0, plo_ff};
               state_ff <= D_CLS;
            end
            D_CLS: begin
               if (n_ff == '0 || r_ff == '0) begin
                  quo_ff <= '0;
                  sat_ff <= 1'b0;
                  done_ff <= 1'b1;
                  state_ff <= D_IDLE;
               end else if (p_ff[95:32] >= d_ff) begin
                  // also covers a zero divisor
                  quo_ff <= '1;
                  sat_ff <= 1'b1;
                  done_ff <= 1'b1;
                  state_ff <= D_IDLE;
               end else begin
                  rem_ff <= p_ff[95:32];
                  low_ff <= p_ff[31:0];
                  quo_ff <= '0;
                  sat_ff <= 1'b0;
                  cnt_ff <= '0;
                  state_ff <= D_ITER;
               end
            end
            D_ITER: begin
               rem_ff <= ge ? 64'(trial - {1'b0, d_ff}) : 64'(trial);
               quo_ff <= {quo_ff[30:0], ge};
               low_ff <= {low_ff[30:0], 1'b0};
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == 5'd31) begin
                  done_ff <= 1'b1;
                  state_ff <= D_IDLE;
               end
            end
            default: state_ff <= D_IDLE;
         endcase
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quo = quo_ff;
   assign rsp.sat = sat_ff;

endmodule

>>> sv/tafl_back.sv
module tafl_back #(
   parameter int GRID_POINTS = tafl_pkg::GRID_POINTS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tafl_pkg::csr_type      csr,
   input  tafl_pkg::cmd_type      cmd,
   input  logic                   cmd_empty,
   output logic                   cmd_pop,
   input  logic                   slot_free,
   output logic                   res_wr,
   output tafl_pkg::rsp_item_type res_item
);

   localparam int AW = $clog2(GRID_POINTS);
   localparam int CW = $clog2(AW + 1);
   localparam int END_W = tafl_pkg::SCORE_W + AW;
   localparam logic [AW-1:0] LAST = AW'(GRID_POINTS - 1);
   localparam logic [2:0] M_DLO = 3'd0;
   localparam logic [2:0] M_DHI = 3'd1;
   localparam logic [2:0] M_RLO = 3'd2;
   localparam logic [2:0] M_RHI = 3'd3;
   localparam logic [2:0] M_DGL = 3'd4;
   localparam logic [2:0] M_RGL = 3'd5;
   localparam logic [2:0] M_END = 3'd6;

   typedef enum logic [3:0] {
      S_IDLE, S_FIN_START, S_FIN_RUN, S_Q_END, S_Q_CMP, S_Q_IDIV, S_Q_WGT,
      S_Q_RDA, S_Q_RDB, S_Q_RDC, S_Q_MUL, S_Q_DIV1, S_Q_DIV2, S_Q_OUT
   } state_type;

   state_type state_ff;
   logic ready_ff, fin_first_ff, last_ff, div_wait_ff, sat_ff;
   logic [AW-1:0] fin_wr_ff, idx_ff;
   logic [tafl_pkg::TAIL_W-1:0] tprev_d_ff, tprev_r_ff;
   logic [31:0] fprev_d_ff, fprev_r_ff;
   logic [23:0] score_ff, step_ff, rem_ff;
   logic [AW-1:0] sh_ff;
   logic [CW-1:0] cnt_ff;
   logic [END_W-1:0] end_ff;
   logic [tafl_pkg::WPROD_W-1:0] wprod_ff;
   logic [tafl_pkg::WEIGHT_W-1:0] w_ff, wn;
   logic [31:0] dci_ff, rci_ff, dci1_ff, rci1_ff;
   logic [tafl_pkg::TAIL_W-1:0] dtail_ff, rtail_ff;
   logic [2:0] mstep_ff;
   logic [tafl_pkg::PROD_W-1:0] prod_ff;
   logic [tafl_pkg::LOC_W-1:0] dloc_ff, rloc_ff;
   logic [tafl_pkg::GLOB_W-1:0] dglob_ff, rglob_ff;
   tafl_pkg::rsp_item_type res_ff;

   // curve and tail stores, one write and one registered read port each
   logic [31:0] dcur_mem [GRID_POINTS];
   logic [31:0] rcur_mem [GRID_POINTS];
   logic [tafl_pkg::TAIL_W-1:0] dtail_mem [GRID_POINTS];
   logic [tafl_pkg::TAIL_W-1:0] rtail_mem [GRID_POINTS];
   logic [31:0] dcur_rd_ff, rcur_rd_ff;
   logic [tafl_pkg::TAIL_W-1:0] dtail_rd_ff, rtail_rd_ff;

   logic cur_we, tail_we;
   logic [AW-1:0] cur_rd_addr, tail_rd_addr;
   logic [tafl_pkg::TAIL_W-1:0] tnew_d, tnew_r;
   logic [24:0] trial;
   logic qbit;
   logic [39:0] wbig;
   logic [33:0] mul_a;
   logic [tafl_pkg::WEIGHT_W-1:0] mul_b;
   logic [tafl_pkg::FD_W-1:0] fd, fr;
   tafl_pkg::div_req_type div_req;
   tafl_pkg::div_rsp_type div_rsp;

   assign cmd_pop = (state_ff == S_IDLE) && !cmd_empty;
   assign cur_we = cmd_pop && (cmd.kind == tafl_pkg::CMD_LOAD);
   assign tail_we = (state_ff == S_FIN_RUN);
   assign res_wr = (state_ff == S_Q_OUT) && slot_free;
   assign res_item = res_ff;

   // read addresses
   always_comb begin
      cur_rd_addr = idx_ff;
      tail_rd_addr = last_ff ? idx_ff : idx_ff + 1'b1;
      case (state_ff)
         S_FIN_START: cur_rd_addr = LAST;
         S_FIN_RUN:   cur_rd_addr = (fin_wr_ff == '0) ? '0 : fin_wr_ff - 1'b1;
         S_Q_RDB:     cur_rd_addr = last_ff ? idx_ff : idx_ff + 1'b1;
         default:     cur_rd_addr = idx_ff;
      endcase
   end

   // tail sweep runs from the top tick down
   assign tnew_d = fin_first_ff ? '0 : tprev_d_ff + tafl_pkg::TAIL_W'(dcur_rd_ff)
                                     + tafl_pkg::TAIL_W'(fprev_d_ff);
   assign tnew_r = fin_first_ff ? '0 : tprev_r_ff + tafl_pkg::TAIL_W'(rcur_rd_ff)
                                     + tafl_pkg::TAIL_W'(fprev_r_ff);

   always_ff @(posedge clock) begin
      if (cur_we && !cmd.curve) begin
         dcur_mem[AW'(cmd.index)] <= cmd.value;
      end
      if (cur_we && cmd.curve) begin
         rcur_mem[AW'(cmd.index)] <= cmd.value;
      end
      dcur_rd_ff <= dcur_mem[cur_rd_addr];
      rcur_rd_ff <= rcur_mem[cur_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (tail_we) begin
         dtail_mem[fin_wr_ff] <= tnew_d;
         rtail_mem[fin_wr_ff] <= tnew_r;
      end
      dtail_rd_ff <= dtail_mem[tail_rd_addr];
      rtail_rd_ff <= rtail_mem[tail_rd_addr];
   end

   // bin index: one restoring division step of score by tick step
   assign trial = {rem_ff, sh_ff[AW-1]};
   assign qbit = trial >= {1'b0, step_ff};

   assign wbig = wprod_ff[55:16];
   assign wn = tafl_pkg::WEIGHT_ONE - w_ff;
   assign fd = tafl_pkg::FD_W'(dloc_ff[48:16]) + tafl_pkg::FD_W'(dci1_ff);
   assign fr = tafl_pkg::FD_W'(rloc_ff[48:16]) + tafl_pkg::FD_W'(rci1_ff);

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (mstep_ff)
         M_DLO: begin mul_a = 34'(dci_ff); mul_b = wn; end
         M_DHI: begin mul_a = last_ff ? '0 : 34'(dci1_ff); mul_b = w_ff; end
         M_RLO: begin mul_a = 34'(rci_ff); mul_b = wn; end
         M_RHI: begin mul_a = last_ff ? '0 : 34'(rci1_ff); mul_b = w_ff; end
         M_DGL: begin mul_a = fd; mul_b = wn; end
         M_RGL: begin mul_a = fr; mul_b = wn; end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   always_comb begin
      div_req.start = ((state_ff == S_Q_DIV1) || (state_ff == S_Q_DIV2)) && !div_wait_ff;
      div_req.ratio = csr.ratio;
      div_req.num = (state_ff == S_Q_DIV2) ? dglob_ff : tafl_pkg::GLOB_W'(dloc_ff);
      div_req.den = (state_ff == S_Q_DIV2) ? rglob_ff : tafl_pkg::GLOB_W'(rloc_ff);
   end

   tafl_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b0;
         div_wait_ff <= 1'b0;
         mstep_ff <= M_END;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (!cmd_empty) begin
                  unique case (cmd.kind)
                     tafl_pkg::CMD_LOAD: ready_ff <= 1'b0;
                     tafl_pkg::CMD_FINISH: state_ff <= S_FIN_START;
                     tafl_pkg::CMD_QUERY: begin
                        score_ff <= cmd.value[23:0];
                        step_ff <= (csr.tick_step == '0) ? 24'd1 : csr.tick_step;
                        if (!ready_ff) begin
                           res_ff.local_fdr <= '0;
                           res_ff.global_fdr <= '0;
                           res_ff.status <= tafl_pkg::STATUS_NOT_READY;
                           state_ff <= S_Q_OUT;
                        end else begin
                           state_ff <= S_Q_END;
                        end
                     end
                     default: state_ff <= S_IDLE;
                  endcase
               end
            end
            S_FIN_START: begin
               fin_wr_ff <= LAST;
               fin_first_ff <= 1'b1;
               state_ff <= S_FIN_RUN;
            end
            S_FIN_RUN: begin
               fprev_d_ff <= dcur_rd_ff;
               fprev_r_ff <= rcur_rd_ff;
               tprev_d_ff <= tnew_d;
               tprev_r_ff <= tnew_r;
               fin_first_ff <= 1'b0;
               if (fin_wr_ff == '0) begin
                  ready_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  fin_wr_ff <= fin_wr_ff - 1'b1;
               end
            end
            S_Q_END: begin
               end_ff <= END_W'(LAST) * END_W'(step_ff);
               state_ff <= S_Q_CMP;
            end
            S_Q_CMP: begin
               if (END_W'(score_ff) >= end_ff) begin
                  // past the last tick: last point, no tail
                  last_ff <= 1'b1;
                  idx_ff <= LAST;
                  w_ff <= '0;
                  state_ff <= S_Q_RDA;
               end else begin
                  last_ff <= 1'b0;
                  rem_ff <= score_ff >> AW;
                  sh_ff <= score_ff[AW-1:0];
                  idx_ff <= '0;
                  cnt_ff <= CW'(AW);
                  state_ff <= S_Q_IDIV;
               end
            end
            S_Q_IDIV: begin
               rem_ff <= qbit ? 24'(trial - {1'b0, step_ff}) : 24'(trial);
               idx_ff <= AW'({idx_ff, qbit});
               sh_ff <= sh_ff << 1;
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == CW'(1)) begin
                  state_ff <= S_Q_WGT;
               end
            end
            S_Q_WGT: begin
               wprod_ff <= tafl_pkg::WPROD_W'(rem_ff) * tafl_pkg::WPROD_W'(csr.step_recip);
               state_ff <= S_Q_RDA;
            end
            S_Q_RDA: begin
               if (!last_ff) begin
                  w_ff <= (wbig > 40'(tafl_pkg::WEIGHT_ONE)) ? tafl_pkg::WEIGHT_ONE
                                                             : wbig[16:0];
               end
               state_ff <= S_Q_RDB;
            end
            S_Q_RDB: begin
               dci_ff <= dcur_rd_ff;
               rci_ff <= rcur_rd_ff;
               state_ff <= S_Q_RDC;
            end
            S_Q_RDC: begin
               dci1_ff <= dcur_rd_ff;
               rci1_ff <= rcur_rd_ff;
               dtail_ff <= dtail_rd_ff;
               rtail_ff <= rtail_rd_ff;
               mstep_ff <= M_DLO;
               state_ff <= S_Q_MUL;
            end
            S_Q_MUL: begin
               prod_ff <= tafl_pkg::PROD_W'(mul_a) * tafl_pkg::PROD_W'(mul_b);
               mstep_ff <= mstep_ff + 1'b1;
               // product of the previous step lands here
               case (mstep_ff)
                  M_DHI: dloc_ff <= tafl_pkg::LOC_W'(prod_ff);
                  M_RLO: dloc_ff <= dloc_ff + tafl_pkg::LOC_W'(prod_ff);
                  M_RHI: rloc_ff <= tafl_pkg::LOC_W'(prod_ff);
                  M_DGL: rloc_ff <= rloc_ff + tafl_pkg::LOC_W'(prod_ff);
                  M_RGL: dglob_ff <= last_ff ? '0
                                    : {dtail_ff, 16'b0} + tafl_pkg::GLOB_W'(prod_ff);
                  M_END: begin
                     rglob_ff <= last_ff ? '0
                                 : {rtail_ff, 16'b0} + tafl_pkg::GLOB_W'(prod_ff);
                     state_ff <= S_Q_DIV1;
                  end
                  default: dloc_ff <= dloc_ff;
               endcase
            end
            S_Q_DIV1: begin
               if (div_req.start) begin
                  div_wait_ff <= 1'b1;
               end
               if (div_rsp.done) begin
                  res_ff.local_fdr <= div_rsp.quo;
                  sat_ff <= div_rsp.sat;
                  div_wait_ff <= 1'b0;
                  state_ff <= S_Q_DIV2;
               end
            end
            S_Q_DIV2: begin
               if (div_req.start) begin
                  div_wait_ff <= 1'b1;
               end
               if (div_rsp.done) begin
                  res_ff.global_fdr <= div_rsp.quo;
                  res_ff.status <= (sat_ff || div_rsp.sat) ? tafl_pkg::STATUS_SAT
                                                           : tafl_pkg::STATUS_OK;
                  div_wait_ff <= 1'b0;
                  state_ff <= S_Q_OUT;
               end
            end
            S_Q_OUT: begin
               if (slot_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

>>> sv/tail_area_fdr_lookup.sv
// channel  | ports                          | moves
// ---------+--------------------------------+------------------------------------
// request  | push, full, req_item           | load, finish or query transaction
// response | empty, pop, rsp_item           | fdr pair and status per query
// csr      | csr_we, csr_index, csr_wdata   | register write, no wait, no read-back
//
// a load is written to its curve store as it is popped and leaves the back end idle; a finish
// sweeps the table (one tick a cycle through the curve store read port); a query's run is
// dominated by the shared bit-serial divider, which runs twice per query; a query with no
// finish since the last load answers not ready without using the divider
// reset is synchronous and active high; stores hold garbage until written
// a two-entry command queue lets requests land while the back end is busy;
// a one-entry result register holds a response until it is popped
`include "tail_area_fdr_lookup_defines.svh"
module tail_area_fdr_lookup #(
   parameter int GRID_POINTS = tafl_pkg::GRID_POINTS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   output logic                                 full,
   input  tafl_pkg::req_item_type               req_item,
   output logic                                 empty,
   input  logic                                 pop,
   output tafl_pkg::rsp_item_type               rsp_item,
   input  logic                                 csr_we,
   input  logic [tafl_pkg::CSR_ADDR_W-1:0]      csr_index,
   input  logic [tafl_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   tafl_pkg::csr_type csr_ff;
   tafl_pkg::cmd_type cmd;
   logic cmd_empty, cmd_pop;
   logic slot_free, res_wr;
   tafl_pkg::rsp_item_type res_item;
   logic rsp_valid_ff;
   tafl_pkg::rsp_item_type rsp_item_ff;

   // configuration registers, to be written by the user only while the block is quiet; the block does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.tick_step <= tafl_pkg::RST_TICK_STEP;
         csr_ff.step_recip <= tafl_pkg::RST_STEP_RECIP;
         csr_ff.score_floor <= tafl_pkg::RST_SCORE_FLOOR;
         csr_ff.ratio <= tafl_pkg::RST_RATIO;
         csr_ff.dens_floor <= tafl_pkg::RST_DENS_FLOOR;
      end else if (csr_we) begin
         unique case (csr_index)
            tafl_pkg::CSR_TICK_STEP:   csr_ff.tick_step <= csr_wdata[23:0];
            tafl_pkg::CSR_STEP_RECIP:  csr_ff.step_recip <= csr_wdata;
            tafl_pkg::CSR_SCORE_FLOOR: csr_ff.score_floor <= csr_wdata[23:0];
            tafl_pkg::CSR_RATIO:       csr_ff.ratio <= csr_wdata;
            tafl_pkg::CSR_DENS_FLOOR:  csr_ff.dens_floor <= csr_wdata;
            default:                   csr_ff <= csr_ff;
         endcase
      end
   end

   // front end: classify and queue commands
   tafl_front #(
      .GRID_POINTS (GRID_POINTS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_item  (req_item),
      .csr       (csr_ff),
      .cmd       (cmd),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop)
   );

   // back end: stores, tail sweep, interpolation and quotients
   tafl_back #(
      .GRID_POINTS (GRID_POINTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_ff),
      .cmd       (cmd),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .slot_free (slot_free),
      .res_wr    (res_wr),
      .res_item  (res_item)
   );

   // result register; freed in the same cycle it is popped
   assign slot_free = !rsp_valid_ff || pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_wr) begin
         rsp_valid_ff <= 1'b1;
      end else if (pop) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_wr) begin
         rsp_item_ff <= res_item;
      end
   end

   assign empty = !rsp_valid_ff;
   assign rsp_item = rsp_item_ff;

   // an unfinished-table answer carries zero rates
   `TAFL_ASSERT(a_not_ready_zero, clock, reset, (!empty && rsp_item.status == tafl_pkg::STATUS_NOT_READY) |-> (rsp_item.local_fdr == '0 && rsp_item.global_fdr == '0), "not ready response with nonzero rate")
   // a written result shows up on the response side next cycle
   `TAFL_ASSERT(a_result_visible, clock, reset, res_wr |=> !empty, "result lost after write")
   // the back end never takes from an empty command queue
   `TAFL_ASSERT_ALWAYS(a_pop_nonempty, clock, cmd_pop |-> !cmd_empty, "command pop while queue empty")

endmodule
